// File: rtl/core/tccw_pkg.sv
// Shared types and constants for the text console cell writer.
// No dependencies; used by tccw_seq and text_console_cell_writer.
package tccw_pkg;

    localparam int DEF_COLS    = 60;
    localparam int DEF_ROWS    = 40;
    localparam int HOME_OFFSET = 2;   // clear homes the cursor to linear cell 2

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [3:0] BLANK_FORE   = 4'd15;
    localparam logic [3:0] BLANK_BACK   = 4'd0;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_ERASE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // one screen cell as stored: back[15:12], fore[11:8], char[7:0]
    typedef struct packed {
        logic [3:0] back;
        logic [3:0] fore;
        logic [7:0] ch;
    } cell_t;

    localparam cell_t BLANK_CELL = '{back: BLANK_BACK, fore: BLANK_FORE, ch: SPACE_CODE};

    typedef struct packed {
        logic [5:0] cursor_col;
        logic [5:0] cursor_row;
        cell_t      rd_cell;
        logic       scrolled;
    } result_t;

endpackage

// File: rtl/core/tccw_cell_ram.sv
// Simple dual-port cell memory: one write port, one registered read port.
// No package dependencies.
module tccw_cell_ram #(
    parameter int DEPTH  = 2400,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/tccw_seq.sv
// Sequencer: cursor state, operation decode and memory walks (clear, scroll, fill).
// Depends on tccw_pkg; drives the port of tccw_cell_ram.
module tccw_seq #(
    parameter int COLS   = tccw_pkg::DEF_COLS,
    parameter int ROWS   = tccw_pkg::DEF_ROWS,
    parameter int ADDR_W = $clog2(COLS * ROWS)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // input item
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              operation,
    input  logic [7:0]              character,
    input  logic [3:0]              fore_color,
    input  logic [3:0]              back_color,
    input  logic [5:0]              read_row,
    input  logic [5:0]              read_col,
    // finished result toward the output register
    output logic                    res_valid,
    input  logic                    res_take,
    output tccw_pkg::result_t       res,
    // memory port
    output logic                    mem_we,
    output logic [ADDR_W-1:0]       mem_waddr,
    output tccw_pkg::cell_t         mem_wdata,
    output logic                    mem_re,
    output logic [ADDR_W-1:0]       mem_raddr,
    input  tccw_pkg::cell_t         mem_rdata
);

    localparam int CELLS    = COLS * ROWS;
    localparam int COL_W    = $clog2(COLS);
    localparam int ROW_W    = $clog2(ROWS);
    localparam int SCAN_W   = $clog2(CELLS + COLS);
    localparam int HOME_ROW = tccw_pkg::HOME_OFFSET / COLS;
    localparam int HOME_COL = tccw_pkg::HOME_OFFSET % COLS;
    localparam int LAST_BASE = CELLS - COLS;

    typedef enum logic [5:0] {
        S_CLR    = 6'b000001,
        S_IDLE   = 6'b000010,
        S_RDW    = 6'b000100,
        S_SCROLL = 6'b001000,
        S_FILL   = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [SCAN_W-1:0]    scan_reg, scan_next;
    logic                 cp_valid_reg, cp_valid_next;
    logic [ADDR_W-1:0]    cp_addr_reg, cp_addr_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic                 res_pend_reg, res_pend_next;
    logic                 scrolled_reg, scrolled_next;
    tccw_pkg::op_t        op_reg, op_next;
    logic [3:0]           fg_reg, fg_next;
    logic [3:0]           bg_reg, bg_next;
    tccw_pkg::cell_t      rcell_reg, rcell_next;

    tccw_pkg::op_t        in_op;
    logic                 is_nl;
    logic                 wrap;
    logic                 last_line;
    logic                 rd_in_range;
    logic [ADDR_W-1:0]    rd_addr;

    assign in_op       = tccw_pkg::op_t'(operation);
    assign is_nl       = (character == tccw_pkg::NEWLINE_CODE);
    assign wrap        = is_nl || (col_reg == COL_W'(COLS - 1));
    assign last_line   = wrap && (row_reg == ROW_W'(ROWS - 1));
    assign rd_in_range = (32'(read_row) < ROWS) && (32'(read_col) < COLS);
    assign rd_addr     = ADDR_W'(32'(read_row) * COLS + 32'(read_col));

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.cursor_col = 6'(col_reg);
    assign res.cursor_row = 6'(row_reg);
    assign res.rd_cell    = rcell_reg;
    assign res.scrolled   = scrolled_reg;

    always_comb
    begin
        state_next    = state_reg;
        scan_next     = scan_reg;
        cp_valid_next = cp_valid_reg;
        cp_addr_next  = cp_addr_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        addr_next     = addr_reg;
        res_pend_next = res_pend_reg;
        scrolled_next = scrolled_reg;
        op_next       = op_reg;
        fg_next       = fg_reg;
        bg_next       = bg_reg;
        rcell_next    = rcell_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = tccw_pkg::BLANK_CELL;
        mem_re        = 1'b0;
        mem_raddr     = '0;

        unique case (state_reg)
            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = scan_reg[ADDR_W-1:0];
                if (scan_reg == SCAN_W'(CELLS - 1))
                begin
                    scan_next     = '0;
                    res_pend_next = 1'b0;
                    state_next    = res_pend_reg ? S_DONE : S_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + SCAN_W'(1);
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = in_op;
                    fg_next       = fore_color;
                    bg_next       = back_color;
                    scrolled_next = 1'b0;
                    rcell_next    = '0;
                    state_next    = S_DONE;
                    unique case (in_op)
                        tccw_pkg::OP_PUT:
                        begin
                            if (!is_nl)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = addr_reg;
                                mem_wdata = '{back: back_color, fore: fore_color,
                                              ch: character};
                            end
                            if (last_line)
                            begin
                                col_next      = '0;
                                row_next      = ROW_W'(ROWS - 1);
                                addr_next     = ADDR_W'(LAST_BASE);
                                scrolled_next = 1'b1;
                                scan_next     = SCAN_W'(COLS);
                                cp_valid_next = 1'b0;
                                state_next    = S_SCROLL;
                            end
                            else if (wrap)
                            begin
                                col_next  = '0;
                                row_next  = row_reg + ROW_W'(1);
                                addr_next = addr_reg + ADDR_W'(COLS) - ADDR_W'(col_reg);
                            end
                            else
                            begin
                                col_next  = col_reg + COL_W'(1);
                                addr_next = addr_reg + ADDR_W'(1);
                            end
                        end

                        tccw_pkg::OP_ERASE:
                        begin
                            if (addr_reg != '0)
                            begin
                                addr_next = addr_reg - ADDR_W'(1);
                                if (col_reg == '0)
                                begin
                                    col_next = COL_W'(COLS - 1);
                                    row_next = row_reg - ROW_W'(1);
                                end
                                else
                                begin
                                    col_next = col_reg - COL_W'(1);
                                end
                                mem_re     = 1'b1;
                                mem_raddr  = addr_reg - ADDR_W'(1);
                                state_next = S_RDW;
                            end
                        end

                        tccw_pkg::OP_CLEAR:
                        begin
                            col_next      = COL_W'(HOME_COL);
                            row_next      = ROW_W'(HOME_ROW);
                            addr_next     = ADDR_W'(tccw_pkg::HOME_OFFSET);
                            scan_next     = '0;
                            res_pend_next = 1'b1;
                            state_next    = S_CLR;
                        end

                        tccw_pkg::OP_READ:
                        begin
                            if (rd_in_range)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = rd_addr;
                                state_next = S_RDW;
                            end
                        end

                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_RDW:
            begin
                // read data for the erase or read issued in the previous cycle
                if (op_reg == tccw_pkg::OP_ERASE)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = addr_reg;
                    mem_wdata = '{back: mem_rdata.back, fore: mem_rdata.fore,
                                  ch: tccw_pkg::SPACE_CODE};
                end
                else
                begin
                    rcell_next = mem_rdata;
                end
                state_next = S_DONE;
            end

            S_SCROLL:
            begin
                // read row r+1 while the cell read last cycle lands one row up
                if (cp_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cp_addr_reg;
                    mem_wdata = mem_rdata;
                end
                if (scan_reg != SCAN_W'(CELLS))
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = scan_reg[ADDR_W-1:0];
                    cp_valid_next = 1'b1;
                    cp_addr_next  = ADDR_W'(scan_reg - SCAN_W'(COLS));
                    scan_next     = scan_reg + SCAN_W'(1);
                end
                else
                begin
                    cp_valid_next = 1'b0;
                    state_next    = S_FILL;
                end
            end

            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(scan_reg - SCAN_W'(COLS));
                mem_wdata = '{back: bg_reg, fore: fg_reg, ch: tccw_pkg::SPACE_CODE};
                if (scan_reg == SCAN_W'(CELLS + COLS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    scan_next = scan_reg + SCAN_W'(1);
                end
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            scan_reg      <= '0;
            cp_valid_reg  <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            addr_reg      <= '0;
            res_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            cp_valid_reg  <= cp_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            addr_reg      <= addr_next;
            res_pend_reg  <= res_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_addr_reg   <= cp_addr_next;
        scrolled_reg  <= scrolled_next;
        op_reg        <= op_next;
        fg_reg        <= fg_next;
        bg_reg        <= bg_next;
        rcell_reg     <= rcell_next;
    end

`ifndef SYNTH
    // no read-during-write on one entry: nothing forwards around the memory
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("memory read and write hit the same entry");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(col_reg) < COLS) && (32'(row_reg) < ROWS))
        else $error("cursor out of screen");

    a_addr_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        addr_reg == ADDR_W'(32'(row_reg) * COLS + 32'(col_reg)))
        else $error("linear cursor address out of step with row and column");

    a_scroll_home: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.scrolled) |->
            ((row_reg == ROW_W'(ROWS - 1)) && (op_reg == tccw_pkg::OP_PUT)))
        else $error("scroll result without cursor on the bottom row");
`endif

endmodule

// File: rtl/core/text_console_cell_writer.sv
// Text console cell writer: character-cell screen memory with cursor and scroll.
// Depends on tccw_pkg, tccw_cell_ram and tccw_seq.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one item per operation: put,
//   erase, clear or read. Output channel (out_valid / out_stall) returns one
//   item per input item, in order: cursor after the operation, the read cell
//   (zero for anything but an in-range read) and the scroll flag.
//   An erase or an in-range read goes through a memory read state before
//   its result is ready; a put, an out-of-range read and an erase at
//   cell 0 do not. A put that scrolls walks the memory once, and clear
//   writes every cell once. One item is in work at a time: the sequencer
//   hands its result to the output register before it accepts again.
//   After reset the block runs a clearing pass over all COLS*ROWS cells
//   (2400 at 60x40) that writes white-on-black spaces to every cell;
//   in_stall stays high meanwhile, cursor at column 0, row 0.
//   While out_stall holds a finished item, the next item may be accepted;
//   its result waits in the sequencer until the output register frees.
module text_console_cell_writer #(
    parameter int COLS = tccw_pkg::DEF_COLS,
    parameter int ROWS = tccw_pkg::DEF_ROWS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    input  logic [7:0] character,
    input  logic [3:0] fore_color,
    input  logic [3:0] back_color,
    input  logic [5:0] read_row,
    input  logic [5:0] read_col,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [5:0] cursor_col,
    output logic [5:0] cursor_row,
    output logic [7:0] cell_char,
    output logic [3:0] cell_fore,
    output logic [3:0] cell_back,
    output logic       scrolled
);

    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    // sequencer <-> memory
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    tccw_pkg::cell_t         mem_wdata;
    logic                    mem_re;
    logic [ADDR_W-1:0]       mem_raddr;
    tccw_pkg::cell_t         mem_rdata;

    // sequencer -> output register
    logic                    res_valid;
    logic                    res_take;
    tccw_pkg::result_t       res;

    // output register
    logic                    out_valid_reg, out_valid_next;
    tccw_pkg::result_t       out_res_reg;

    tccw_cell_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W),
        .DATA_W ($bits(tccw_pkg::cell_t))
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tccw_seq #(
        .COLS   (COLS),
        .ROWS   (ROWS),
        .ADDR_W (ADDR_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .character  (character),
        .fore_color (fore_color),
        .back_color (back_color),
        .read_row   (read_row),
        .read_col   (read_col),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    // load when the output register is empty or is being drained this cycle
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cursor_col = out_res_reg.cursor_col;
    assign cursor_row = out_res_reg.cursor_row;
    assign cell_char  = out_res_reg.rd_cell.ch;
    assign cell_fore  = out_res_reg.rd_cell.fore;
    assign cell_back  = out_res_reg.rd_cell.back;
    assign scrolled   = out_res_reg.scrolled;

endmodule

// File: bench/testbench.sv
// Self-checking bench for text_console_cell_writer: random and directed console
// operations, an in-bench screen tracker that predicts every output item.
// Depends on tccw_pkg and the RTL of text_console_cell_writer.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS         = tccw_pkg::DEF_COLS;
    localparam int ROWS         = tccw_pkg::DEF_ROWS;
    localparam int CELLS        = COLS * ROWS;
    localparam int RANDOM_ITEMS = 600;
    localparam int LONG_HOLD    = 400;   // receiver hold-off, in cycles
    localparam int TAIL_CYCLES  = 20;
    // Worst case: every item scrolls (a full memory walk, budgeted here with
    // a row to spare) plus idle gaps, the clearing pass after reset and the
    // long holds; taken 3x over.
    localparam int LIMIT_CYCLES =
        3 * ((RANDOM_ITEMS + 40) * (CELLS + COLS + 3 + 40) + CELLS + 2 * LONG_HOLD);

    // ------------------------------------------------------------------
    // Screen tracker: shadow copy of the cell memory and cursor. Each
    // accepted item is applied here and its expected status is queued.
    // ------------------------------------------------------------------
    class screen_tracker;
        tccw_pkg::cell_t   screen [CELLS];
        int unsigned       cursor_off;
        tccw_pkg::result_t status_queue [$];
        int                errors;

        function new();
            foreach (screen[i])
                screen[i] = tccw_pkg::BLANK_CELL;
            cursor_off = 0;
            errors     = 0;
        endfunction

        function void apply_op(tccw_pkg::op_t op, logic [7:0] ch, logic [3:0] fg,
                               logic [3:0] bg, logic [5:0] row, logic [5:0] col);
            tccw_pkg::result_t want;
            int unsigned       off;
            off  = cursor_off;
            want = '0;
            case (op)
                tccw_pkg::OP_PUT:
                begin
                    if (ch == tccw_pkg::NEWLINE_CODE)
                        off = off - off % COLS + COLS;
                    else
                    begin
                        screen[off] = '{back: bg, fore: fg, ch: ch};
                        off++;
                    end
                    // ran past the last cell: scroll everything up one row
                    if (off >= CELLS)
                    begin
                        for (int i = COLS; i < CELLS; i++)
                            screen[i - COLS] = screen[i];
                        for (int i = CELLS - COLS; i < CELLS; i++)
                            screen[i] = '{back: bg, fore: fg, ch: tccw_pkg::SPACE_CODE};
                        off -= COLS;
                        want.scrolled = 1'b1;
                    end
                end
                tccw_pkg::OP_ERASE:
                begin
                    if (off > 0)
                    begin
                        off--;
                        screen[off].ch = tccw_pkg::SPACE_CODE;   // colors are kept
                    end
                end
                tccw_pkg::OP_CLEAR:
                begin
                    foreach (screen[i])
                        screen[i] = tccw_pkg::BLANK_CELL;
                    off = tccw_pkg::HOME_OFFSET;
                end
                default:
                begin
                    if (row < ROWS && col < COLS)
                        want.rd_cell = screen[row * COLS + col];
                end
            endcase
            cursor_off      = off;
            want.cursor_col = 6'(off % COLS);
            want.cursor_row = 6'(off / COLS);
            status_queue.push_back(want);
        endfunction

        function void check_field(string name, int unsigned want_v, int unsigned got_v);
            if (want_v != got_v)
            begin
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, name, want_v, got_v);
                errors++;
            end
        endfunction

        function void compare_status(tccw_pkg::result_t got);
            tccw_pkg::result_t want;
            if (status_queue.size() == 0)
            begin
                $display("%0t: output item with no expected item pending", $time);
                errors++;
                return;
            end
            want = status_queue.pop_front();
            check_field("cursor_col", want.cursor_col, got.cursor_col);
            check_field("cursor_row", want.cursor_row, got.cursor_row);
            check_field("cell_char", want.rd_cell.ch, got.rd_cell.ch);
            check_field("cell_fore", want.rd_cell.fore, got.rd_cell.fore);
            check_field("cell_back", want.rd_cell.back, got.rd_cell.back);
            check_field("scrolled", want.scrolled, got.scrolled);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    logic [1:0] operation  = '0;
    logic [7:0] character  = '0;
    logic [3:0] fore_color = '0;
    logic [3:0] back_color = '0;
    logic [5:0] read_row   = '0;
    logic [5:0] read_col   = '0;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    logic [5:0] cursor_col;
    logic [5:0] cursor_row;
    logic [7:0] cell_char;
    logic [3:0] cell_fore;
    logic [3:0] cell_back;
    logic       scrolled;

    int unsigned   items_accepted = 0;
    int unsigned   items_sent     = 0;
    int unsigned   cycle_count    = 0;
    screen_tracker tracker        = new();

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    text_console_cell_writer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .character  (character),
        .fore_color (fore_color),
        .back_color (back_color),
        .read_row   (read_row),
        .read_col   (read_col),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .cell_char  (cell_char),
        .cell_fore  (cell_fore),
        .cell_back  (cell_back),
        .scrolled   (scrolled)
    );

    // Idle roll shared by both sides; a window of items runs with no idling.
    function automatic bit idle_now();
        if (items_accepted >= 250 && items_accepted < 330)
            return 1'b0;
        return $urandom_range(0, 99) < 22;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: outputs are checked before the input at the same edge is
    // applied, since a result at this edge always belongs to an older item.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                tracker.compare_status(tccw_pkg::result_t'({cursor_col, cursor_row,
                                                            cell_back, cell_fore,
                                                            cell_char, scrolled}));
            if (in_valid && !in_stall)
            begin
                tracker.apply_op(tccw_pkg::op_t'(operation), character, fore_color,
                                 back_color, read_row, read_col);
                items_accepted++;
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off now and then so the
    // block backs up and stalls its input while the sender keeps offering.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned hold_left;
        int unsigned next_hold_at;
        hold_left    = 0;
        next_hold_at = 120;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && items_accepted >= next_hold_at)
            begin
                hold_left    = LONG_HOLD;
                next_hold_at = next_hold_at + 330;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
                out_stall = idle_now();
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks. Valid stays high from item to item unless an idle
    // cycle is rolled; the payload holds while stalled.
    // ------------------------------------------------------------------
    task automatic send_item(input tccw_pkg::op_t op, input logic [7:0] ch,
                             input logic [3:0] fg, input logic [3:0] bg,
                             input logic [5:0] row, input logic [5:0] col);
        @(negedge clk);
        while (idle_now())
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        operation  = op;
        character  = ch;
        fore_color = fg;
        back_color = bg;
        read_row   = row;
        read_col   = col;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // Sender pause: nothing offered until every result is back.
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (tracker.status_queue.size() != 0)
            @(posedge clk);
    endtask

    // Read near the cursor almost half the time (that is where puts, erases and
    // scrolls leave marks), elsewhere otherwise, sometimes off the screen.
    task automatic send_random_read();
        int unsigned roll;
        int unsigned base_row;
        logic [5:0]  row;
        logic [5:0]  col;
        roll     = $urandom_range(0, 99);
        base_row = tracker.cursor_off / COLS;
        if (roll < 45)
        begin
            row = 6'((base_row > 0 && $urandom_range(0, 1)) ? base_row - 1 : base_row);
            col = 6'($urandom_range(0, COLS - 1));
        end
        else if (roll < 85)
        begin
            row = 6'($urandom_range(0, ROWS - 1));
            col = 6'($urandom_range(0, COLS - 1));
        end
        else
        begin
            row = 6'($urandom_range(0, 63));
            col = 6'($urandom_range(0, 63));
        end
        send_item(tccw_pkg::OP_READ, 8'($urandom_range(0, 255)),
                  4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), row, col);
    endtask

    task automatic send_random_put(input logic [7:0] ch);
        send_item(tccw_pkg::OP_PUT, ch, 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                  6'($urandom_range(0, 63)));
    endtask

    task automatic send_random_plain(input tccw_pkg::op_t op);
        send_item(op, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                  6'($urandom_range(0, 63)));
    endtask

    // ------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned kind;
        int unsigned count;
        int unsigned roll;
        bit          paused;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: blank screen, erase at cell zero, field extremes,
        // erase keeping colors, newline, corner and off-screen reads, clear.
        send_item(tccw_pkg::OP_READ,  8'h00, 4'h0, 4'h0, 6'd0, 6'd0);
        send_item(tccw_pkg::OP_ERASE, 8'h00, 4'h0, 4'h0, 6'd0, 6'd0);
        send_item(tccw_pkg::OP_PUT,   8'h00, 4'h0, 4'hF, 6'd0, 6'd0);
        send_item(tccw_pkg::OP_PUT,   8'hFF, 4'hF, 4'h0, 6'd63, 6'd63);
        send_item(tccw_pkg::OP_PUT,   8'h55, 4'hA, 4'h5, 6'd0, 6'd0);
        send_item(tccw_pkg::OP_READ,  8'h00, 4'h0, 4'h0, 6'd0, 6'd0);
        send_item(tccw_pkg::OP_READ,  8'h00, 4'h0, 4'h0, 6'd0, 6'd1);
        send_item(tccw_pkg::OP_ERASE, 8'hFF, 4'hF, 4'hF, 6'd63, 6'd63);
        send_item(tccw_pkg::OP_READ,  8'hFF, 4'hF, 4'hF, 6'd0, 6'd2);
        send_item(tccw_pkg::OP_PUT,   tccw_pkg::NEWLINE_CODE, 4'h3, 4'hC, 6'd0, 6'd0);
        send_item(tccw_pkg::OP_PUT,   8'h78, 4'h3, 4'hC, 6'd0, 6'd0);
        send_item(tccw_pkg::OP_READ,  8'h00, 4'h0, 4'h0, 6'd1, 6'd0);
        send_item(tccw_pkg::OP_READ,  8'h00, 4'h0, 4'h0, 6'(ROWS - 1), 6'(COLS - 1));
        send_item(tccw_pkg::OP_READ,  8'h00, 4'h0, 4'h0, 6'(ROWS), 6'd0);
        send_item(tccw_pkg::OP_READ,  8'h00, 4'h0, 4'h0, 6'd0, 6'(COLS));
        send_item(tccw_pkg::OP_READ,  8'h00, 4'h0, 4'h0, 6'd63, 6'd63);
        send_item(tccw_pkg::OP_CLEAR, 8'h41, 4'h7, 4'h7, 6'd5, 6'd5);
        send_item(tccw_pkg::OP_READ,  8'h00, 4'h0, 4'h0, 6'd1, 6'd0);
        send_item(tccw_pkg::OP_ERASE, 8'h00, 4'h0, 4'h0, 6'd0, 6'd0);
        send_item(tccw_pkg::OP_ERASE, 8'h00, 4'h0, 4'h0, 6'd0, 6'd0);
        send_item(tccw_pkg::OP_ERASE, 8'h00, 4'h0, 4'h0, 6'd0, 6'd0);
        send_item(tccw_pkg::OP_PUT,   tccw_pkg::NEWLINE_CODE, 4'h0, 4'h0, 6'd0, 6'd0);
        wait_for_drain();

        // Random: mostly typed lines with interleaved reads and erases, runs
        // of newlines that carry the cursor to the bottom and make it
        // scroll, read bursts, occasional clears and erase runs.
        items_sent = 0;
        paused     = 1'b0;
        while (items_sent < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 50)
            begin
                count = $urandom_range(0, 70);
                repeat (count)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 20)
                        send_random_read();
                    else if (roll < 28)
                        send_random_plain(tccw_pkg::OP_ERASE);
                    else
                        send_random_put(8'($urandom_range(0, 255)));
                end
                send_random_put(tccw_pkg::NEWLINE_CODE);
            end
            else if (kind < 65)
            begin
                count = $urandom_range(3, 30);
                repeat (count)
                    send_random_put(tccw_pkg::NEWLINE_CODE);
            end
            else if (kind < 88)
            begin
                count = $urandom_range(1, 8);
                repeat (count)
                    send_random_read();
            end
            else if (kind < 92)
                send_random_plain(tccw_pkg::OP_CLEAR);
            else
            begin
                count = $urandom_range(1, 10);
                repeat (count)
                    send_random_plain(tccw_pkg::OP_ERASE);
            end

            if (!paused && items_sent >= RANDOM_ITEMS / 2)
            begin
                wait_for_drain();
                paused = 1'b1;
            end
        end

        // End of run: drain, then a short tail for anything stray.
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.status_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: text_console_cell_writer.f
rtl/core/tccw_pkg.sv
rtl/core/tccw_cell_ram.sv
rtl/core/tccw_seq.sv
rtl/core/text_console_cell_writer.sv
bench/testbench.sv
